/* hdl/assert_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hdl/eiu_pkg.sv */
// Shared types and constants for the Ethernet/IPv4/UDP header parser.
package eiu_pkg;

    localparam int COUNT_BITS = 16;
    typedef logic [COUNT_BITS-1:0] count_t;
    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    // header offsets and limits
    localparam count_t OFS_ETYPE_HI = count_t'(12);
    localparam count_t OFS_ETYPE_LO = count_t'(13);
    localparam count_t OFS_VER_IHL  = count_t'(14);
    localparam count_t OFS_PROTO    = count_t'(23);
    localparam count_t MIN_FRAME    = count_t'(42);
    localparam logic [6:0] ETH_LEN  = 7'd14;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [3:0]  IP_VERSION_4   = 4'd4;
    localparam logic [5:0]  IP_HDR_MIN     = 6'd20;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] UDP_HDR_LEN    = 16'd8;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_NOT_IPV4,
        ST_BAD_VER_IHL,
        ST_NOT_UDP,
        ST_SHORT_HDR,
        ST_BAD_UDP_LEN,
        ST_TRUNCATED
    } status_t;

    // work for the back end: an optional payload byte, an optional verdict
    typedef struct packed {
        logic        has_pay;
        logic [7:0]  pay_byte;
        logic        has_verdict;
        status_t     status;
        logic [15:0] dst_port;
        logic [15:0] pay_len;
    } cmd_t;

    // command queue, depth a power of two
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    typedef logic [FIFO_AW-1:0] fifo_ptr_t;
    typedef logic [FIFO_CW-1:0] fifo_cnt_t;
    localparam fifo_cnt_t FIFO_FULL_CNT = fifo_cnt_t'(FIFO_DEPTH);

endpackage

/* hdl/eiu_stream_if.sv */
// Valid/ready stream interfaces for frame bytes and parser results.
interface eiu_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       end_of_frame;

    modport source (output valid, output frame_byte, output end_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input end_of_frame, output ready);
endinterface

interface eiu_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic        last;
    logic [2:0]  status;
    logic [15:0] dst_port;
    logic [15:0] pay_len;

    modport source (output valid, output kind, output payload_byte, output last,
                    output status, output dst_port, output pay_len, input ready);
    modport sink   (input valid, input kind, input payload_byte, input last,
                    input status, input dst_port, input pay_len, output ready);
endinterface

/* hdl/eiu_front.sv */
// Front end: takes frame bytes, tracks header fields and builds back-end commands.
`include "assert_macros.svh"

module eiu_front
(
    input  logic          clk,
    input  logic          rst_n,
    eiu_frame_if.sink     frames,
    input  logic          fifo_full,
    output logic          push,
    output eiu_pkg::cmd_t cmd
);

    eiu_pkg::count_t cnt_reg, cnt_next;
    logic [15:0] etype_reg, etype_next;
    logic [5:0]  ihb_reg, ihb_next;
    logic [3:0]  ver_reg, ver_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] udp_len_reg, udp_len_next;
    logic [15:0] port_reg, port_next;
    logic [15:0] emitted_reg, emitted_next;

    logic            accept;
    logic [7:0]      b;
    logic            eof;
    logic [6:0]      udp_at;
    eiu_pkg::count_t udp_at_c;
    eiu_pkg::count_t len;
    logic            hdr_good;
    logic [15:0]     pay_room;
    logic            pay;
    logic [15:0]     emitted_new;
    eiu_pkg::status_t status;

    assign frames.ready = !fifo_full;
    assign accept       = frames.valid && frames.ready;
    assign b            = frames.frame_byte;
    assign eof          = frames.end_of_frame;

    // all header fields are settled in earlier bytes wherever they decide a result
    assign udp_at   = eiu_pkg::ETH_LEN + {1'b0, ihb_reg};
    assign udp_at_c = eiu_pkg::count_t'(udp_at);
    assign len      = (cnt_reg == eiu_pkg::COUNT_MAX) ? cnt_reg
                                                       : cnt_reg + eiu_pkg::count_t'(1);
    assign hdr_good = (etype_reg == eiu_pkg::ETHERTYPE_IPV4) &&
                      (ver_reg == eiu_pkg::IP_VERSION_4) &&
                      (ihb_reg >= eiu_pkg::IP_HDR_MIN) &&
                      (proto_reg == eiu_pkg::PROTO_UDP) &&
                      (udp_len_reg >= eiu_pkg::UDP_HDR_LEN);
    assign pay_room = udp_len_reg - eiu_pkg::UDP_HDR_LEN;
    assign pay      = (cnt_reg >= udp_at_c + eiu_pkg::count_t'(8)) && hdr_good &&
                      (emitted_reg < pay_room);
    assign emitted_new = emitted_reg + {15'd0, pay};

    always_comb
    begin
        if (len < eiu_pkg::MIN_FRAME)
            status = eiu_pkg::ST_SHORT;
        else if (etype_reg != eiu_pkg::ETHERTYPE_IPV4)
            status = eiu_pkg::ST_NOT_IPV4;
        else if (ver_reg != eiu_pkg::IP_VERSION_4 || ihb_reg < eiu_pkg::IP_HDR_MIN)
            status = eiu_pkg::ST_BAD_VER_IHL;
        else if (proto_reg != eiu_pkg::PROTO_UDP)
            status = eiu_pkg::ST_NOT_UDP;
        else if (len < udp_at_c + eiu_pkg::count_t'(8))
            status = eiu_pkg::ST_SHORT_HDR;
        else if (udp_len_reg < eiu_pkg::UDP_HDR_LEN)
            status = eiu_pkg::ST_BAD_UDP_LEN;
        else if (emitted_new < pay_room)
            status = eiu_pkg::ST_TRUNCATED;
        else
            status = eiu_pkg::ST_OK;
    end

    always_comb
    begin
        cmd.has_pay     = pay;
        cmd.pay_byte    = b;
        cmd.has_verdict = eof;
        cmd.status      = status;
        cmd.dst_port    = (status == eiu_pkg::ST_OK) ? port_reg : 16'd0;
        cmd.pay_len     = (status == eiu_pkg::ST_OK) ? pay_room : 16'd0;
    end

    assign push = accept && (pay || eof);

    always_comb
    begin
        cnt_next     = cnt_reg;
        etype_next   = etype_reg;
        ihb_next     = ihb_reg;
        ver_next     = ver_reg;
        proto_next   = proto_reg;
        udp_len_next = udp_len_reg;
        port_next    = port_reg;
        emitted_next = emitted_reg;
        if (accept)
        begin
            if (eof)
            begin
                cnt_next     = '0;
                etype_next   = '0;
                ihb_next     = '0;
                ver_next     = '0;
                proto_next   = '0;
                udp_len_next = '0;
                port_next    = '0;
                emitted_next = '0;
            end
            else
            begin
                cnt_next     = len;
                emitted_next = emitted_new;
                if (cnt_reg == eiu_pkg::OFS_ETYPE_HI)
                    etype_next[15:8] = b;
                if (cnt_reg == eiu_pkg::OFS_ETYPE_LO)
                    etype_next[7:0] = b;
                if (cnt_reg == eiu_pkg::OFS_VER_IHL)
                begin
                    ver_next = b[7:4];
                    ihb_next = {b[3:0], 2'b00};
                end
                if (cnt_reg == eiu_pkg::OFS_PROTO)
                    proto_next = b;
                if (cnt_reg == udp_at_c + eiu_pkg::count_t'(2))
                    port_next[15:8] = b;
                if (cnt_reg == udp_at_c + eiu_pkg::count_t'(3))
                    port_next[7:0] = b;
                if (cnt_reg == udp_at_c + eiu_pkg::count_t'(4))
                    udp_len_next[15:8] = b;
                if (cnt_reg == udp_at_c + eiu_pkg::count_t'(5))
                    udp_len_next[7:0] = b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            etype_reg   <= '0;
            ihb_reg     <= '0;
            ver_reg     <= '0;
            proto_reg   <= '0;
            udp_len_reg <= '0;
            port_reg    <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            etype_reg   <= etype_next;
            ihb_reg     <= ihb_next;
            ver_reg     <= ver_next;
            proto_reg   <= proto_next;
            udp_len_reg <= udp_len_next;
            port_reg    <= port_next;
            emitted_reg <= emitted_next;
        end
    end

    // smallest legal header stack puts the first payload word at offset 42
    `ASSERT_CLK(a_pay_offset, (push && pay) |-> cnt_reg >= eiu_pkg::MIN_FRAME, "early payload")

endmodule

/* hdl/eiu_cmd_fifo.sv */
// Short command queue between the parser front end and the result back end.
`include "assert_macros.svh"

module eiu_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  eiu_pkg::cmd_t cmd_in,
    input  logic          pop,
    output eiu_pkg::cmd_t cmd_out,
    output logic          not_empty,
    output logic          full
);

    eiu_pkg::cmd_t     slot_reg [eiu_pkg::FIFO_DEPTH];
    eiu_pkg::fifo_ptr_t wr_ptr_reg, rd_ptr_reg;
    eiu_pkg::fifo_cnt_t count_reg;

    assign cmd_out   = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == eiu_pkg::FIFO_FULL_CNT);

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + eiu_pkg::fifo_ptr_t'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + eiu_pkg::fifo_ptr_t'(1);
            if (push && !pop)
                count_reg <= count_reg + eiu_pkg::fifo_cnt_t'(1);
            else if (pop && !push)
                count_reg <= count_reg - eiu_pkg::fifo_cnt_t'(1);
        end
    end

    `ASSERT_NEVER(a_pop_empty, pop && (count_reg == '0), "pop from empty command queue")
    `ASSERT_NEVER(a_push_full, push && !pop && full, "push into full command queue")

endmodule

/* hdl/eiu_back.sv */
// Back end: expands queued commands into result words behind an output register.
`include "assert_macros.svh"

module eiu_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  eiu_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          pop,
    eiu_result_if.source  results
);

    logic        valid_reg;
    logic        phase_reg;    // payload half of a two-word command already sent
    logic        kind_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [2:0]  status_reg;
    logic [15:0] port_reg;
    logic [15:0] plen_reg;

    logic load;
    logic emit_pay;

    assign load     = cmd_valid && (!valid_reg || results.ready);
    assign emit_pay = cmd.has_pay && !phase_reg;
    assign pop      = load && !(emit_pay && cmd.has_verdict);

    assign results.valid        = valid_reg;
    assign results.kind         = kind_reg;
    assign results.payload_byte = byte_reg;
    assign results.last         = last_reg;
    assign results.status       = status_reg;
    assign results.dst_port     = port_reg;
    assign results.pay_len      = plen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= emit_pay && cmd.has_verdict;
            end
            else if (results.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (emit_pay)
            begin
                kind_reg   <= eiu_pkg::KIND_PAYLOAD;
                byte_reg   <= cmd.pay_byte;
                last_reg   <= !cmd.has_verdict;
                status_reg <= eiu_pkg::ST_OK;
                port_reg   <= 16'd0;
                plen_reg   <= 16'd0;
            end
            else
            begin
                kind_reg   <= eiu_pkg::KIND_VERDICT;
                byte_reg   <= 8'd0;
                last_reg   <= 1'b1;
                status_reg <= cmd.status;
                port_reg   <= cmd.dst_port;
                plen_reg   <= cmd.pay_len;
            end
        end
    end

    `ASSERT_CLK(a_verdict_last, (valid_reg && kind_reg) |-> last_reg, "verdict word without last")
    `ASSERT_CLK(a_phase_hold, phase_reg |-> (cmd_valid && cmd.has_verdict), "split command lost")

endmodule

/* hdl/eth_ipv4_udp_header_parser_core.sv */
// Top level of the Ethernet/IPv4/UDP header parser.
// Takes one frame byte per clock on frames (valid/ready) and gives result words on
// results: UDP payload bytes as they arrive, then one verdict word on the frame's final
// byte. Payload words come out before the verdict, so drop them when the verdict status
// is not ok. A byte is taken every cycle while the four-entry command queue has room;
// each byte that yields a result gives the back end one result word, and a final byte
// that also carries a payload byte gives two. The header bytes of the next frame yield
// nothing, so the queue soaks up that extra word and bytes go in at one per clock while
// results are taken every cycle. The first result word of a byte passes through the
// command queue and then the output register; while that word waits for ready the
// back end holds and the front end keeps filling the queue.
module eth_ipv4_udp_header_parser_core
(
    input  logic         clk,
    input  logic         rst_n,
    eiu_frame_if.sink    frames,
    eiu_result_if.source results
);

    eiu_pkg::cmd_t push_cmd;
    eiu_pkg::cmd_t head_cmd;
    logic          push;
    logic          pop;
    logic          fifo_full;
    logic          fifo_not_empty;

    eiu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .frames    (frames),
        .fifo_full (fifo_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    eiu_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_in    (push_cmd),
        .pop       (pop),
        .cmd_out   (head_cmd),
        .not_empty (fifo_not_empty),
        .full      (fifo_full)
    );

    eiu_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (fifo_not_empty),
        .pop       (pop),
        .results   (results)
    );

endmodule
